### hdl/lzsd_pkg.sv
// Shared types and constants for the LZ77 stream decoder.
// Used by lzsd_ctrl, lzsd_datapath and lz77_stream_decoder; no dependencies.
package lzsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LIT_BITS = 8;

   // Token field being gathered from the bit stream
   typedef enum logic [1:0] {
      STG_FLAG = 2'd0,
      STG_LIT  = 2'd1,
      STG_LEN  = 2'd2,
      STG_DIST = 2'd3
   } stage_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_BITS    = 3'd1,
      ST_COPY_RD = 3'd2,
      ST_COPY_WR = 3'd3,
      ST_FLUSH   = 3'd4
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture a new code word
      logic step;   // consume one bit of the code word
      logic rd;     // read history at copy source
      logic wr;     // write/emit one copied byte
      logic flush;  // release held result marked as last
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic bits_more;  // unconsumed bits left and stream not finished
      logic match_go;   // next bit completes a match distance
      logic hold_room;  // hold stage can take a new result
      logic hold_v;     // hold stage has a result
      logic out_room;   // output register can take a word
      logic copy_last;  // copy counter on its final byte
   } sts_type;

endpackage

### hdl/lz77_stream_decoder.sv
// Sequence: a code word is accepted, its bits are consumed one at a time, the used-up word is
//   seen, each copied byte takes a history read, then a write/emit, and the result is flushed.
// A new code word is taken only after the previous one is flushed; a full hold stage stalls
//   the bit walk and copies. The history memory read-then-write per copied byte sets the match rate.
// Reset: synchronous, active high; clears token state, write pointer and valid flags.
//   The ring needs no clearing pass: unwritten entries are tracked by pointer and wrap flag.
module lz77_stream_decoder #(
   parameter int DIST_BITS    = 13,  // 8..16, history ring is 2**DIST_BITS bytes
   parameter int LEN_BITS     = 4,   // 2..8, all-ones code ends the stream
   parameter int MIN_LEN_BIAS = 2    // 1..4, match length = code + bias + 1
) (
   input  logic       clock,
   input  logic       reset,
   // compressed stream in
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] code_byte
   // decoded stream out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] is_end
   output logic       rsp_tlast    // last word caused by one input word
);
   import lzsd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller: walks the 8 bits of a word, runs match copies, then flushes
   // the held result with its last marker.
   lzsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: token fields, history ring, one-word hold stage and output register.
   lzsd_datapath #(
      .DIST_BITS    (DIST_BITS),
      .LEN_BITS     (LEN_BITS),
      .MIN_LEN_BIAS (MIN_LEN_BIAS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_tdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_byte  (rsp_tdata),
      .rsp_end   (rsp_tuser),
      .rsp_last  (rsp_tlast),
      .cmd       (cmd),
      .sts       (sts)
   );

   // At most one command per cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // A result is only produced when the hold stage can take it.
   a_hold_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.wr) |-> sts.hold_room)
      else $error("result produced with hold stage blocked");

   // A new word is taken only after the previous one's results are flushed.
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.hold_v)
      else $error("input ready while a result is still held");

   // A copy read is always followed by its write phase.
   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> !cmd.rd && !cmd.step && !req_tready)
      else $error("copy read not followed by write phase");

endmodule

### hdl/lzsd_ctrl.sv
// Sequencer for the LZ77 stream decoder: bit stepping, match copy, result flush.
// Depends on lzsd_pkg.
module lzsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  lzsd_pkg::sts_type sts,
   output lzsd_pkg::cmd_type cmd
);
   import lzsd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_BITS;
         end
         ST_BITS: begin
            if (!sts.bits_more) begin
               state_in = ST_FLUSH;
            end else if (sts.hold_room && sts.match_go) begin
               state_in = ST_COPY_RD;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            if (sts.hold_room) state_in = sts.copy_last ? ST_BITS : ST_COPY_RD;
         end
         ST_FLUSH: begin
            if (!sts.hold_v || sts.out_room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_BITS: begin
            cmd.step = sts.bits_more && sts.hold_room;
         end
         ST_COPY_RD: begin
            cmd.rd = 1'b1;
         end
         ST_COPY_WR: begin
            cmd.wr = sts.hold_room;
         end
         ST_FLUSH: begin
            cmd.flush = !sts.hold_v || sts.out_room;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### hdl/lzsd_datapath.sv
// Datapath of the LZ77 stream decoder: bit unpacking, history ring, hold and output stage.
// Depends on lzsd_pkg; driven by lzsd_ctrl commands.
module lzsd_datapath #(
   parameter int DIST_BITS    = 13,
   parameter int LEN_BITS     = 4,
   parameter int MIN_LEN_BIAS = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lzsd_pkg::BYTE_W-1:0]   req_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [lzsd_pkg::BYTE_W-1:0]   rsp_byte,
   output logic                          rsp_end,
   output logic                          rsp_last,
   input  lzsd_pkg::cmd_type             cmd,
   output lzsd_pkg::sts_type             sts
);
   import lzsd_pkg::*;

   localparam int RING_DEPTH = 1 << DIST_BITS;
   localparam int ACC_W      = (DIST_BITS > LIT_BITS) ? DIST_BITS : LIT_BITS;
   localparam int TK_W       = $clog2(ACC_W);
   localparam int PLEN_W     = LEN_BITS + 1;  // code + bias + 1 fits for bias <= 4
   localparam logic [LEN_BITS-1:0] END_CODE = '1;

   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [3:0]           bitcnt_ff, bitcnt_in;
   stage_type            stage_ff, stage_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [TK_W-1:0]      taken_ff, taken_in;
   logic [PLEN_W-1:0]    plen_ff, plen_in;
   logic [PLEN_W-1:0]    cnt_ff, cnt_in;
   logic [DIST_BITS-1:0] src_ff, src_in;
   logic [DIST_BITS-1:0] wp_ff, wp_in;
   logic                 wrapped_ff, wrapped_in;
   logic                 finished_ff, finished_in;
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_ok_ff;
   logic                 hold_v_ff, hold_v_in;
   logic [BYTE_W-1:0]    hold_byte_ff, hold_byte_in;
   logic                 hold_end_ff, hold_end_in;
   logic                 out_v_ff, out_v_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_end_ff, out_end_in;
   logic                 out_last_ff, out_last_in;

   logic                 bit_cur;
   logic [ACC_W-1:0]     acc_new;
   logic [TK_W:0]        taken_p1;
   logic [TK_W:0]        fld_len;
   logic                 fld_done;
   logic                 res_now;
   logic [BYTE_W-1:0]    res_byte;
   logic                 res_end;
   logic                 new_res;
   logic                 mem_we;
   logic [BYTE_W-1:0]    mem_wd;
   logic [BYTE_W-1:0]    copy_byte;
   logic                 out_room;

   assign bit_cur   = byte_ff[0];
   assign acc_new   = acc_ff | (ACC_W'(bit_cur) << taken_ff);
   assign taken_p1  = {1'b0, taken_ff} + (TK_W+1)'(1);
   assign copy_byte = rd_ok_ff ? rd_data_ff : '0;  // never-written entries read as zero
   assign out_room  = !out_v_ff || rsp_ready;

   always_comb begin
      case (stage_ff)
         STG_LIT:  fld_len = (TK_W+1)'(LIT_BITS);
         STG_LEN:  fld_len = (TK_W+1)'(LEN_BITS);
         default:  fld_len = (TK_W+1)'(DIST_BITS);
      endcase
   end
   assign fld_done = (taken_p1 == fld_len);

   always_comb begin
      byte_in      = byte_ff;
      bitcnt_in    = bitcnt_ff;
      stage_in     = stage_ff;
      acc_in       = acc_ff;
      taken_in     = taken_ff;
      plen_in      = plen_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      finished_in  = finished_ff;
      res_now      = 1'b0;
      res_byte     = '0;
      res_end      = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = copy_byte;

      if (cmd.load) begin
         byte_in   = req_data;
         bitcnt_in = '0;
      end

      if (cmd.step) begin
         byte_in   = {1'b0, byte_ff[BYTE_W-1:1]};
         bitcnt_in = bitcnt_ff + 4'd1;
         case (stage_ff)
            STG_FLAG: begin
               stage_in = bit_cur ? STG_LEN : STG_LIT;
               acc_in   = '0;
               taken_in = '0;
            end
            STG_LIT: begin
               if (fld_done) begin
                  res_now  = 1'b1;
                  res_byte = acc_new[BYTE_W-1:0];
                  mem_we   = 1'b1;
                  mem_wd   = acc_new[BYTE_W-1:0];
                  stage_in = STG_FLAG;
               end else begin
                  acc_in   = acc_new;
                  taken_in = taken_p1[TK_W-1:0];
               end
            end
            STG_LEN: begin
               if (fld_done) begin
                  acc_in   = '0;
                  taken_in = '0;
                  if (acc_new[LEN_BITS-1:0] == END_CODE) begin
                     res_now     = 1'b1;
                     res_end     = 1'b1;
                     finished_in = 1'b1;
                     stage_in    = STG_FLAG;
                  end else begin
                     plen_in  = PLEN_W'(acc_new[LEN_BITS-1:0]) + PLEN_W'(MIN_LEN_BIAS)
                                + PLEN_W'(1);
                     stage_in = STG_DIST;
                  end
               end else begin
                  acc_in   = acc_new;
                  taken_in = taken_p1[TK_W-1:0];
               end
            end
            default: begin
               if (fld_done) begin
                  src_in   = wp_ff - acc_new[DIST_BITS-1:0];
                  cnt_in   = plen_ff;
                  stage_in = STG_FLAG;
                  acc_in   = '0;
                  taken_in = '0;
               end else begin
                  acc_in   = acc_new;
                  taken_in = taken_p1[TK_W-1:0];
               end
            end
         endcase
      end

      if (cmd.wr) begin
         mem_we = 1'b1;
         mem_wd = copy_byte;
         src_in = src_ff + DIST_BITS'(1);
         cnt_in = cnt_ff - PLEN_W'(1);
      end

      if (mem_we) begin
         wp_in = wp_ff + DIST_BITS'(1);
         if (wp_ff == '1) wrapped_in = 1'b1;
      end
   end

   assign new_res = (cmd.step && res_now) || cmd.wr;

   // hold stage keeps the newest result until we know whether it is the last one
   always_comb begin
      hold_v_in    = hold_v_ff;
      hold_byte_in = hold_byte_ff;
      hold_end_in  = hold_end_ff;
      out_v_in     = out_v_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;

      if (new_res) begin
         hold_v_in    = 1'b1;
         hold_byte_in = cmd.wr ? copy_byte : res_byte;
         hold_end_in  = cmd.wr ? 1'b0 : res_end;
      end else if (cmd.flush) begin
         hold_v_in = 1'b0;
      end

      if ((new_res || cmd.flush) && hold_v_ff) begin
         out_v_in    = 1'b1;
         out_byte_in = hold_byte_ff;
         out_end_in  = hold_end_ff;
         out_last_in = cmd.flush;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= STG_FLAG;
         acc_ff      <= '0;
         taken_ff    <= '0;
         plen_ff     <= '0;
         bitcnt_ff   <= 4'd8;
         wp_ff       <= '0;
         wrapped_ff  <= 1'b0;
         finished_ff <= 1'b0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         stage_ff    <= stage_in;
         acc_ff      <= acc_in;
         taken_ff    <= taken_in;
         plen_ff     <= plen_in;
         bitcnt_ff   <= bitcnt_in;
         wp_ff       <= wp_in;
         wrapped_ff  <= wrapped_in;
         finished_ff <= finished_in;
         hold_v_ff   <= hold_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      cnt_ff       <= cnt_in;
      src_ff       <= src_in;
      hold_byte_ff <= hold_byte_in;
      hold_end_ff  <= hold_end_in;
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
   end

   // history ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[wp_ff] <= mem_wd;
      if (cmd.rd) begin
         rd_data_ff <= ring_mem[src_ff];
         rd_ok_ff   <= wrapped_ff || (src_ff < wp_ff);
      end
   end

   assign sts.bits_more = !finished_ff && !bitcnt_ff[3];
   assign sts.match_go  = (stage_ff == STG_DIST) && fld_done;
   assign sts.hold_room = !hold_v_ff || out_room;
   assign sts.hold_v    = hold_v_ff;
   assign sts.out_room  = out_room;
   assign sts.copy_last = (cnt_ff == PLEN_W'(1));

   assign rsp_valid = out_v_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_end   = out_end_ff;
   assign rsp_last  = out_last_ff;

endmodule

### verif/tb_lz77_stream_decoder.sv
// Self-checking bench for lz77_stream_decoder: directed and random token streams are packed
// into code words, decoded by a scoreboard class and checked word by word on the rsp stream.
// Depends on lzsd_pkg and the lz77_stream_decoder RTL.
module tb_lz77_stream_decoder;
   import lzsd_pkg::*;

   localparam int DIST_BITS    = 13;
   localparam int LEN_BITS     = 4;
   localparam int MIN_LEN_BIAS = 2;
   localparam int RING_DEPTH   = 1 << DIST_BITS;
   localparam int END_CODE     = (1 << LEN_BITS) - 1;

   localparam int RANDOM_WORDS = 380;     // code words in the random part
   localparam int TRAIL_WORDS  = 6;       // words sent after the end token
   localparam int STALL_AFTER  = 120;     // sink holds off after this many results
   localparam int STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;     // extra wait after all due words are seen
   localparam int CYCLE_LIMIT  = 300000;

   // one decoded word as seen on the rsp side
   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
      logic       last;
   } out_word_type;

   // Keeps its own copy of the decoder state and the words still due from the block.
   class lz_decode_scoreboard;
      logic [7:0]           ring [RING_DEPTH];
      logic [DIST_BITS-1:0] wr_ptr;
      stage_type            stage;
      logic [15:0]          field;
      int                   field_len;
      int                   copy_len;
      bit                   finished;
      out_word_type         held;        // newest word, gets tlast at end of the code word
      bit                   held_v;
      out_word_type         words_due[$];
      int                   errors;
      int                   words_in;
      int                   words_out;
      int                   copies;
      int                   ends;

      function new();
         foreach (ring[i]) ring[i] = 8'h00;
         wr_ptr    = '0;
         stage     = STG_FLAG;
         field     = '0;
         field_len = 0;
         copy_len  = 0;
         finished  = 1'b0;
         held_v    = 1'b0;
         errors    = 0;
         words_in  = 0;
         words_out = 0;
         copies    = 0;
         ends      = 0;
      endfunction

      function void queue_word(logic [7:0] data, logic is_end);
         if (held_v) words_due.push_back(held);
         held.data   = data;
         held.is_end = is_end;
         held.last   = 1'b0;
         held_v      = 1'b1;
      endfunction

      function void store_byte(logic [7:0] data);
         ring[wr_ptr] = data;
         wr_ptr++;
         queue_word(data, 1'b0);
      endfunction

      // Walks the 8 bits of one accepted code word, LSB first.
      function void note_code_word(logic [7:0] code);
         logic [DIST_BITS-1:0] src;
         words_in++;
         for (int b = 0; b < 8; b++) begin
            if (!finished) begin
               if (stage == STG_FLAG) begin
                  stage     = code[b] ? STG_LEN : STG_LIT;
                  field     = '0;
                  field_len = 0;
               end else begin
                  field[field_len] = code[b];
                  field_len++;
                  case (stage)
                     STG_LIT: begin
                        if (field_len == LIT_BITS) begin
                           store_byte(field[7:0]);
                           stage = STG_FLAG;
                        end
                     end
                     STG_LEN: begin
                        if (field_len == LEN_BITS) begin
                           if (field[LEN_BITS-1:0] == END_CODE[LEN_BITS-1:0]) begin
                              // end marker: rest of this word and all later words ignored
                              queue_word(8'h00, 1'b1);
                              finished = 1'b1;
                              ends++;
                              stage = STG_FLAG;
                           end else begin
                              copy_len = int'(field[LEN_BITS-1:0]) + MIN_LEN_BIAS + 1;
                              stage    = STG_DIST;
                           end
                           field     = '0;
                           field_len = 0;
                        end
                     end
                     default: begin
                        if (field_len == DIST_BITS) begin
                           // byte-by-byte copy, so overlap repeats freshly written data
                           src = wr_ptr - field[DIST_BITS-1:0];
                           for (int n = 0; n < copy_len; n++) begin
                              store_byte(ring[src]);
                              src++;
                           end
                           copies++;
                           stage     = STG_FLAG;
                           field     = '0;
                           field_len = 0;
                        end
                     end
                  endcase
               end
            end
         end
         if (held_v) begin
            held.last = 1'b1;
            words_due.push_back(held);
            held_v = 1'b0;
         end
      endfunction

      function void check_out_word(logic [7:0] data, logic is_end, logic last);
         out_word_type due;
         words_out++;
         if (words_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp word data=%h is_end=%b last=%b",
                     $time, data, is_end, last);
         end else begin
            due = words_due.pop_front();
            if (data !== due.data) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %h actual %h", $time, due.data, data);
            end
            if (is_end !== due.is_end) begin
               errors++;
               $display("%0t: is_end mismatch, expected %b actual %b",
                        $time, due.is_end, is_end);
            end
            if (last !== due.last) begin
               errors++;
               $display("%0t: last mismatch, expected %b actual %b", $time, due.last, last);
            end
         end
      endfunction

      function int pending();
         return words_due.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] code_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tuser;           // [0] is_end
   logic       rsp_tlast;

   int unsigned cycle_count = 0;

   lz_decode_scoreboard sb;

   // packed token stream: bits wait here until a whole code word is formed
   bit         bit_fifo[$];
   logic [7:0] code_words[$];

   lz77_stream_decoder #(
      .DIST_BITS   (DIST_BITS),
      .LEN_BITS    (LEN_BITS),
      .MIN_LEN_BIAS(MIN_LEN_BIAS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Append count bits of value LSB first; full code words move to code_words.
   function automatic void put_bits(int unsigned value, int count);
      logic [7:0] w;
      for (int i = 0; i < count; i++) bit_fifo.push_back(value[i]);
      while (bit_fifo.size() >= 8) begin
         for (int k = 0; k < 8; k++) w[k] = bit_fifo.pop_front();
         code_words.push_back(w);
      end
   endfunction

   function automatic void add_literal(int unsigned value);
      put_bits(0, 1);
      put_bits(value, LIT_BITS);
   endfunction

   function automatic void add_copy(int unsigned len_code, int unsigned distance);
      put_bits(1, 1);
      put_bits(len_code, LEN_BITS);
      put_bits(distance, DIST_BITS);
   endfunction

   // End token, then random filler up to the word boundary (ignored by the block).
   function automatic void add_end_token();
      put_bits(1, 1);
      put_bits(END_CODE, LEN_BITS);
      while (bit_fifo.size() != 0) put_bits($urandom_range(0, 1), 1);
   endfunction

   // Well-formed token with random content; never the end code.
   function automatic void add_random_token();
      int unsigned pick;
      int unsigned distance;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         add_literal($urandom_range(0, 255));
      end else begin
         pick = $urandom_range(0, 9);
         if (pick == 0) distance = 0;
         else if (pick < 5) distance = $urandom_range(1, 8);      // short, overlapping runs
         else if (pick < 7) distance = $urandom_range(9, 300);
         else distance = $urandom_range(0, RING_DEPTH - 1);     // anywhere, often unwritten
         add_copy($urandom_range(0, END_CODE - 1), distance);
      end
   endfunction

   // Offer every code word in turn with random gaps; at pause_at hold until the
   // block has returned every word due so far.
   task automatic send_code_words(int pause_at);
      int gap;
      bit steady;
      steady = 1'b0;
      for (int i = 0; i < code_words.size(); i++) begin
         if (i % 32 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
            gap = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 5);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= code_words[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.note_code_word(code_words[i]);
      end
      req_tvalid <= 1'b0;
   endtask

   // Result sink: random ready gaps, plus one long hold-off so the block backs up
   // and stalls its input while the sender keeps offering words.
   initial begin : out_sink
      int gap;
      int got;
      bit steady;
      got    = 0;
      steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (got % 32 == 0) steady = ($urandom_range(0, 3) == 0);
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_out_word(rsp_tdata, rsp_tuser, rsp_tlast);
         got++;
         if (got == STALL_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[lz77_stream_decoder] ERROR");
      $finish;
   end

   initial begin : main_seq
      int pause_at;
      sb = new();

      // Directed tokens. The first code word is all zeros (literal 0x00); the long
      // copy with distance 8191 packs enough ones for an all-ones code word.
      add_literal(8'h00);
      add_literal(8'hFF);
      add_copy(0, 4000);             // shortest copy from never-written ring: zeros
      add_literal(8'hA5);
      add_copy(END_CODE - 1, 1);     // longest copy, overlapping by one byte
      add_copy(5, 0);                // distance zero re-reads the write pointer slot
      add_copy(END_CODE - 1, RING_DEPTH - 1);  // largest distance
      add_literal(8'h5A);
      add_literal(8'h3C);
      add_copy(3, 2);
      pause_at = code_words.size();

      // random part; partial token bits carry over from the directed part
      while (code_words.size() < pause_at + RANDOM_WORDS) add_random_token();
      add_end_token();
      // after the end token nothing more may come out
      repeat (TRAIL_WORDS) code_words.push_back(8'($urandom_range(0, 255)));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_code_words(pause_at);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d code words in, %0d decoded words out, %0d copies, %0d end token(s)",
               sb.words_in, sb.words_out, sb.copies, sb.ends);
      $display("run: %0d mismatches, %0d words still due", sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[lz77_stream_decoder] OK");
      end else begin
         $display("[lz77_stream_decoder] ERROR");
      end
      $finish;
   end

endmodule
